FILE: rtl/pfgb_pkg.sv
package pfgb_pkg;

    localparam int unsigned FB_WIDTH_DEF    = 128;
    localparam int unsigned FB_HEIGHT_DEF   = 64;
    localparam int unsigned FONT_GLYPHS_DEF = 96;

    // wide enough for the largest framebuffer (256 x 16 pages) and font (224 x 8)
    localparam int unsigned MEM_AW_MAX = 12;

    localparam logic [7:0] FIRST_CODE = 8'h20;

    localparam logic [1:0] REQ_FONT  = 2'd0;
    localparam logic [1:0] REQ_PIXEL = 2'd1;
    localparam logic [1:0] REQ_GLYPH = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       pixel_value;
        logic [7:0] char_code;
        logic [2:0] glyph_row;
        logic [7:0] row_bits;
        logic [9:0] fb_addr;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
    } rsp_t;

    // one write and one read port of a byte-wide memory
    typedef struct packed {
        logic                  we;
        logic [MEM_AW_MAX-1:0] waddr;
        logic [7:0]            wdata;
        logic                  re;
        logic [MEM_AW_MAX-1:0] raddr;
    } mem_ctl_t;

    typedef struct packed {
        logic                  on;
        logic [MEM_AW_MAX-1:0] addr;
        logic [7:0]            mask;
    } pix_t;

endpackage

FILE: rtl/pfgb_if.sv
interface pfgb_req_if import pfgb_pkg::*;;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pfgb_rsp_if import pfgb_pkg::*;;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/page_framebuffer_glyph_blit_unit.sv
// page-layout monochrome framebuffer with an 8x8 glyph blitter
// req channel: one beat per request (font row load, pixel write, glyph draw,
// framebuffer byte read); rsp channel: exactly one beat back per request,
// read_data is the byte for reads and zero for everything else
// a glyph draw goes one pixel per cycle through the shared address unit and
// a read-modify-write pipe on the framebuffer memory; a code outside the
// font is answered without drawing
// one request at a time: req.ready rises again right after the response
// beat is taken
// after reset the framebuffer is cleared one byte a cycle, which keeps req.ready
// low until all FB_WIDTH * ceil(FB_HEIGHT / 8) bytes (1024 by default) are written;
// the font memory is not cleared and must be loaded before glyphs are drawn
// a stalled rsp holds its beat and no new request is taken until it leaves
module page_framebuffer_glyph_blit_unit import pfgb_pkg::*;
#(
    parameter int unsigned FB_WIDTH    = FB_WIDTH_DEF,
    parameter int unsigned FB_HEIGHT   = FB_HEIGHT_DEF,
    parameter int unsigned FONT_GLYPHS = FONT_GLYPHS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    pfgb_req_if.sink   req,
    pfgb_rsp_if.source rsp
);

    localparam int unsigned FB_BYTES   = FB_WIDTH * ((FB_HEIGHT + 7) / 8);
    localparam int unsigned FONT_BYTES = 8 * FONT_GLYPHS;

    mem_ctl_t   fb_ctl;
    mem_ctl_t   font_ctl;
    logic [7:0] fb_rd;
    logic [7:0] font_rd;

    pfgb_ram #(
        .DEPTH (FB_BYTES)
    ) u_fb_ram (
        .clk     (clk),
        .mem_ctl (fb_ctl),
        .rd_data (fb_rd)
    );

    pfgb_ram #(
        .DEPTH (FONT_BYTES)
    ) u_font_ram (
        .clk     (clk),
        .mem_ctl (font_ctl),
        .rd_data (font_rd)
    );

    pfgb_ctrl #(
        .FB_WIDTH    (FB_WIDTH),
        .FB_HEIGHT   (FB_HEIGHT),
        .FONT_GLYPHS (FONT_GLYPHS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .fb_ctl   (fb_ctl),
        .fb_rd    (fb_rd),
        .font_ctl (font_ctl),
        .font_rd  (font_rd)
    );

endmodule

FILE: rtl/pfgb_ram.sv
module pfgb_ram import pfgb_pkg::*;
#(
    parameter int unsigned DEPTH = FB_WIDTH_DEF * ((FB_HEIGHT_DEF + 7) / 8)
)
(
    input  logic       clk,
    input  mem_ctl_t   mem_ctl,
    output logic [7:0] rd_data
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_ctl.we)
        begin
            mem[mem_ctl.waddr[AW-1:0]] <= mem_ctl.wdata;
        end
        if (mem_ctl.re)
        begin
            rd_data <= mem[mem_ctl.raddr[AW-1:0]];
        end
    end

endmodule

FILE: rtl/pfgb_pix.sv
module pfgb_pix import pfgb_pkg::*;
#(
    parameter int unsigned FB_WIDTH  = FB_WIDTH_DEF,
    parameter int unsigned FB_HEIGHT = FB_HEIGHT_DEF
)
(
    input  logic [7:0] base_x,
    input  logic [7:0] base_y,
    input  logic [2:0] off_c,
    input  logic [2:0] off_r,
    output pix_t       pix
);

    logic [8:0] x9;
    logic [8:0] y9;
    logic [8:0] rx9;
    logic [8:0] ry9;
    logic [8:0] page;

    always_comb
    begin
        x9   = {1'b0, base_x} + {6'b0, off_c};
        y9   = {1'b0, base_y} + {6'b0, off_r};
        // image is stored rotated by 180 degrees
        rx9  = 9'(FB_WIDTH - 1) - x9;
        ry9  = 9'(FB_HEIGHT - 1) - y9;
        page = ry9 >> 3;
        pix.on   = (32'(x9) < FB_WIDTH) && (32'(y9) < FB_HEIGHT);
        pix.addr = MEM_AW_MAX'(32'(page) * FB_WIDTH) + MEM_AW_MAX'(rx9);
        pix.mask = 8'd1 << ry9[2:0];
    end

endmodule

FILE: rtl/pfgb_ctrl.sv
module pfgb_ctrl import pfgb_pkg::*;
#(
    parameter int unsigned FB_WIDTH    = FB_WIDTH_DEF,
    parameter int unsigned FB_HEIGHT   = FB_HEIGHT_DEF,
    parameter int unsigned FONT_GLYPHS = FONT_GLYPHS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    pfgb_req_if.sink   req,
    pfgb_rsp_if.source rsp,
    output mem_ctl_t   fb_ctl,
    input  logic [7:0] fb_rd,
    output mem_ctl_t   font_ctl,
    input  logic [7:0] font_rd
);

    localparam int unsigned FB_PAGES = (FB_HEIGHT + 7) / 8;
    localparam int unsigned FB_BYTES = FB_WIDTH * FB_PAGES;
    localparam int unsigned FB_AW    = $clog2(FB_BYTES);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_FONT   = 3'd2;
    localparam logic [2:0] ST_PIX    = 3'd3;
    localparam logic [2:0] ST_GSTART = 3'd4;
    localparam logic [2:0] ST_DRAW   = 3'd5;
    localparam logic [2:0] ST_READ   = 3'd6;
    localparam logic [2:0] ST_RWAIT  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [FB_AW-1:0] clr_reg, clr_next;
    logic [5:0]       pix_reg, pix_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    req_t             req_reg, req_next;

    // write-back stage of the pixel read-modify-write
    logic                  b_valid_reg, b_valid_next;
    logic [MEM_AW_MAX-1:0] b_addr_reg, b_addr_next;
    logic [7:0]            b_mask_reg, b_mask_next;
    logic                  b_val_reg, b_val_next;

    logic [2:0] off_c;
    logic [2:0] off_r;
    logic       pix_val;
    pix_t       pix;
    logic       code_ok;
    logic       addr_ok;
    logic [7:0] glyph_idx;

    pfgb_pix #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_pix (
        .base_x (req_reg.pos_x),
        .base_y (req_reg.pos_y),
        .off_c  (off_c),
        .off_r  (off_r),
        .pix    (pix)
    );

    assign glyph_idx = req_reg.char_code - FIRST_CODE;
    assign code_ok   = (req_reg.char_code >= FIRST_CODE) && (32'(glyph_idx) < FONT_GLYPHS);
    assign addr_ok   = 32'(req_reg.fb_addr) < FB_BYTES;

    assign req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = '{read_data: out_data_reg};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pix_next       = pix_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        b_valid_next   = 1'b0;
        off_c          = 3'd0;
        off_r          = 3'd0;
        pix_val        = req_reg.pixel_value;
        fb_ctl         = '0;
        font_ctl       = '0;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (b_valid_reg)
        begin
            fb_ctl.we    = 1'b1;
            fb_ctl.waddr = b_addr_reg;
            fb_ctl.wdata = b_val_reg ? (fb_rd | b_mask_reg) : (fb_rd & ~b_mask_reg);
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                fb_ctl.we    = 1'b1;
                fb_ctl.waddr = MEM_AW_MAX'(clr_reg);
                fb_ctl.wdata = 8'd0;
                if (clr_reg == FB_AW'(FB_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    req_next = req.data;
                    unique case (req.data.req_type)
                        REQ_FONT:  state_next = ST_FONT;
                        REQ_PIXEL: state_next = ST_PIX;
                        REQ_GLYPH: state_next = ST_GSTART;
                        REQ_READ:  state_next = ST_READ;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FONT:
            begin
                font_ctl.we    = code_ok;
                font_ctl.waddr = MEM_AW_MAX'({glyph_idx, req_reg.glyph_row});
                font_ctl.wdata = req_reg.row_bits;
                out_valid_next = 1'b1;
                out_data_next  = 8'd0;
                state_next     = ST_IDLE;
            end
            ST_PIX:
            begin
                b_valid_next   = pix.on;
                fb_ctl.re      = 1'b1;
                fb_ctl.raddr   = pix.addr;
                out_valid_next = 1'b1;
                out_data_next  = 8'd0;
                state_next     = ST_IDLE;
            end
            ST_GSTART:
            begin
                if (code_ok)
                begin
                    font_ctl.re    = 1'b1;
                    font_ctl.raddr = MEM_AW_MAX'({glyph_idx, 3'd0});
                    pix_next       = 6'd0;
                    state_next     = ST_DRAW;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = 8'd0;
                    state_next     = ST_IDLE;
                end
            end
            ST_DRAW:
            begin
                off_c        = pix_reg[2:0];
                off_r        = pix_reg[5:3];
                // bit 7 of a font row is the leftmost column
                pix_val      = font_rd[~pix_reg[2:0]];
                b_valid_next = pix.on;
                fb_ctl.re    = 1'b1;
                fb_ctl.raddr = pix.addr;
                // fetch the next font row during the last column
                if (pix_reg[2:0] == 3'd7 && pix_reg[5:3] != 3'd7)
                begin
                    font_ctl.re    = 1'b1;
                    font_ctl.raddr = MEM_AW_MAX'({glyph_idx, pix_reg[5:3] + 3'd1});
                end
                if (pix_reg == 6'd63)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = 8'd0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    pix_next = pix_reg + 6'd1;
                end
            end
            ST_READ:
            begin
                fb_ctl.re    = addr_ok;
                fb_ctl.raddr = MEM_AW_MAX'(req_reg.fb_addr);
                state_next   = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = addr_ok ? fb_rd : 8'd0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        b_addr_next = pix.addr;
        b_mask_next = pix.mask;
        b_val_next  = pix_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pix_reg       <= pix_next;
            out_valid_reg <= out_valid_next;
            b_valid_reg   <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
        b_addr_reg   <= b_addr_next;
        b_mask_reg   <= b_mask_next;
        b_val_reg    <= b_val_next;
    end

    a_wb_after_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> ($past(state_reg) == ST_PIX || $past(state_reg) == ST_DRAW))
        else $error("write-back without a pixel step");

    a_font_row_fetched: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW && pix_reg[2:0] == 3'd0) |-> $past(font_ctl.re))
        else $error("glyph row drawn without a font fetch");

    a_no_rmw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (fb_ctl.we && fb_ctl.re) |-> (fb_ctl.waddr != fb_ctl.raddr))
        else $error("framebuffer read and write hit the same byte");

    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_IDLE))
        else $error("result pending while busy");

endmodule
